// ===== hw/rtl/hgbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hgbs_pkg
// Shared types and constants of the height grid bilinear sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package hgbs_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_QUERY    = 2'd1;
    localparam logic [1:0] OP_RESAMPLE = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_GRID_SIZE   = 3'd0;
    localparam logic [2:0] CFG_RECT_LEFT   = 3'd1;
    localparam logic [2:0] CFG_RECT_TOP    = 3'd2;
    localparam logic [2:0] CFG_RECT_RIGHT  = 3'd3;
    localparam logic [2:0] CFG_RECT_BOTTOM = 3'd4;
    localparam logic [2:0] CFG_OUT_SIZE    = 3'd5;

    // grid address field of a queue entry, wide enough for the largest grid
    localparam int ADDR_W_MAX = 20;
    // blend datapath widths
    localparam int MOP_W = 35;
    localparam int ACC_W = 56;

    localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

    typedef enum logic [1:0] {
        K_WRITE,
        K_CONST,
        K_READ0,
        K_BLEND
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [ADDR_W_MAX-1:0]   addr;
        logic [31:0]             data;
        logic signed [17:0]      wx;
        logic signed [17:0]      wy;
    } q_entry_t;

    typedef struct packed {
        logic signed [17:0] rect_left;
        logic signed [17:0] rect_top;
        logic signed [17:0] rect_right;
        logic signed [17:0] rect_bottom;
        logic [8:0]         out_size;
    } cfg_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_BASE,
        F_SPAN,
        F_TERM,
        F_START,
        F_DIV,
        F_SUM,
        F_SPLIT,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_R0,
        B_A,
        B_B,
        B_C,
        B_D,
        B_E,
        B_F,
        B_G,
        B_H,
        B_FIN,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hgbs_div.sv =====
// ----------------------------------------------------------------------------
// hgbs_div
// Signed by unsigned radix-2 restoring divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hgbs_div #(
    parameter int W = 38
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [W-1:0] dividend,
    input  wire logic [8:0]          divisor,
    output logic                     busy,
    output logic signed [W-1:0]      quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg;
    logic [8:0]    r_reg;
    logic [8:0]    d_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic          busy_reg;
    logic [9:0]    r_shift;
    logic [9:0]    r_sub;
    logic          fits;

    assign r_shift = {r_reg, q_reg[W-1]};
    assign r_sub   = r_shift - {1'b0, d_reg};
    assign fits    = r_shift >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[W-1] ? W'(-dividend) : W'(dividend);
            r_reg   <= '0;
            d_reg   <= divisor;
            neg_reg <= dividend[W-1];
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[W-2:0], fits};
            r_reg <= fits ? r_sub[8:0] : r_shift[8:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? $signed(-q_reg) : $signed(q_reg);

endmodule

`default_nettype wire

// ===== hw/rtl/hgbs_front.sv =====
// ----------------------------------------------------------------------------
// hgbs_front
// Accepts items, classifies them and works out grid cell and weights.
// ----------------------------------------------------------------------------
`default_nettype none

module hgbs_front
    import hgbs_pkg::*;
#(
    parameter int GRID_MAX = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire cfg_t                              cfg,
    input  wire logic [$clog2(GRID_MAX+1)-1:0]     n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        operation,
    input  wire logic [15:0]                       sample_index,
    input  wire logic signed [31:0]                sample_value,
    input  wire logic signed [17:0]                point_x,
    input  wire logic signed [17:0]                point_y,
    input  wire logic [7:0]                        out_col,
    input  wire logic [7:0]                        out_row,
    output logic                                   q_push,
    output q_entry_t                               q_entry,
    input  wire logic                              q_full
);

    localparam int NW  = $clog2(GRID_MAX + 1);
    localparam int CAP = GRID_MAX * GRID_MAX;
    localparam int DXW = 20 + NW;
    localparam int DW  = DXW + 9;
    localparam int PW  = DW + 1;

    typedef struct packed {
        logic [NW-1:0]      cidx;
        logic signed [17:0] w;
    } split_t;

    front_state_t state_reg, state_next;

    logic                    is_query_reg;
    logic signed [17:0]      px_reg, py_reg;
    logic [7:0]              col_reg, row_reg;
    logic signed [PW-1:0]    pos_x_reg, pos_y_reg;
    logic signed [DXW-1:0]   dx_reg, dy_reg;
    logic signed [DW-1:0]    tx_reg, ty_reg;
    split_t                  sx_reg, sy_reg;
    kind_t                   ent_kind_reg;
    logic [ADDR_W_MAX-1:0]   ent_addr_reg;
    logic [31:0]             ent_data_reg;

    logic                    accept;
    logic                    go_push, go_base;
    kind_t                   dec_kind;
    logic [NW-1:0]           n1;
    logic signed [NW:0]      n1_s;
    logic signed [18:0]      diff_x, diff_y;
    logic                    div_start;
    logic                    busy_x, busy_y;
    logic signed [DW-1:0]    qx, qy;
    logic [2*NW-1:0]         base_full;

    assign accept = in_valid && in_ready;
    assign n1     = n - 1'b1;
    assign n1_s   = $signed({1'b0, n1});
    assign diff_x = 19'(cfg.rect_right) - 19'(cfg.rect_left);
    assign diff_y = 19'(cfg.rect_bottom) - 19'(cfg.rect_top);

    function automatic split_t split_axis(input logic signed [PW-1:0] pos,
                                          input logic [NW-1:0] nn);
        split_t                r;
        logic signed [PW-1:0]  i;
        logic signed [PW-1:0]  lim;
        i   = pos >>> 16;
        lim = PW'($signed({1'b0, nn - 1'b1}));
        if (pos < -PW'(65535))
        begin
            r.cidx = '0;
            r.w    = '0;
        end
        else if (pos < 0)
        begin
            // weight stays negative between -1 and 0
            r.cidx = '0;
            r.w    = 18'(pos);
        end
        else if (i >= lim)
        begin
            r.cidx = nn - NW'(2);
            r.w    = ONE_Q16;
        end
        else
        begin
            r.cidx = i[NW-1:0];
            r.w    = $signed({2'b00, pos[15:0]});
        end
        return r;
    endfunction

    // item classification
    always_comb
    begin
        go_push  = 1'b0;
        go_base  = 1'b0;
        dec_kind = K_CONST;
        unique case (operation)
            OP_WRITE:
            begin
                dec_kind = K_WRITE;
                go_push  = 32'(sample_index) < 32'(CAP);
            end
            OP_QUERY:
            begin
                if (n == '0)
                begin
                    dec_kind = K_CONST;
                    go_push  = 1'b1;
                end
                else if (n == NW'(1))
                begin
                    dec_kind = K_READ0;
                    go_push  = 1'b1;
                end
                else
                begin
                    dec_kind = K_BLEND;
                    go_base  = 1'b1;
                end
            end
            OP_RESAMPLE:
            begin
                if (cfg.out_size > 9'd1)
                begin
                    if (n < NW'(2))
                    begin
                        dec_kind = K_CONST;
                        go_push  = 1'b1;
                    end
                    else
                    begin
                        dec_kind = K_BLEND;
                        go_base  = 1'b1;
                    end
                end
            end
            default:
            begin
                go_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && go_push)
                    state_next = F_PUSH;
                else if (accept && go_base)
                    state_next = F_BASE;
            end
            F_BASE:  state_next = is_query_reg ? F_SPLIT : F_SPAN;
            F_SPAN:  state_next = F_TERM;
            F_TERM:  state_next = F_START;
            F_START: state_next = F_DIV;
            F_DIV:
            begin
                if (!busy_x && !busy_y)
                    state_next = F_SUM;
            end
            F_SUM:   state_next = F_SPLIT;
            F_SPLIT: state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == F_IDLE);
        q_push    = (state_reg == F_PUSH) && !q_full;
        div_start = (state_reg == F_START);
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    ent_kind_reg <= dec_kind;
                    ent_addr_reg <= (dec_kind == K_WRITE) ? ADDR_W_MAX'(sample_index) : '0;
                    ent_data_reg <= sample_value;
                    is_query_reg <= (operation == OP_QUERY);
                    px_reg       <= point_x;
                    py_reg       <= point_y;
                    col_reg      <= out_col;
                    row_reg      <= out_row;
                end
            end
            F_BASE:
            begin
                // query position, or the rectangle origin of a resample
                pos_x_reg <= PW'(is_query_reg ? px_reg : cfg.rect_left) * PW'(n1_s);
                pos_y_reg <= PW'(is_query_reg ? py_reg : cfg.rect_top) * PW'(n1_s);
            end
            F_SPAN:
            begin
                dx_reg <= DXW'(diff_x) * DXW'(n1_s);
                dy_reg <= DXW'(diff_y) * DXW'(n1_s);
            end
            F_TERM:
            begin
                tx_reg <= DW'(dx_reg) * DW'($signed({1'b0, col_reg}));
                ty_reg <= DW'(dy_reg) * DW'($signed({1'b0, row_reg}));
            end
            F_SUM:
            begin
                pos_x_reg <= pos_x_reg + PW'(qx);
                pos_y_reg <= pos_y_reg + PW'(qy);
            end
            F_SPLIT:
            begin
                sx_reg <= split_axis(pos_x_reg, n);
                sy_reg <= split_axis(pos_y_reg, n);
            end
            default:
            begin
            end
        endcase
    end

    hgbs_div #(.W(DW)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tx_reg),
        .divisor  (cfg.out_size - 9'd1),
        .busy     (busy_x),
        .quotient (qx)
    );

    hgbs_div #(.W(DW)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ty_reg),
        .divisor  (cfg.out_size - 9'd1),
        .busy     (busy_y),
        .quotient (qy)
    );

    assign base_full = (2*NW)'(sx_reg.cidx) + (2*NW)'(sy_reg.cidx) * (2*NW)'(n);

    always_comb
    begin
        q_entry.kind = ent_kind_reg;
        q_entry.addr = (ent_kind_reg == K_BLEND) ? ADDR_W_MAX'(base_full) : ent_addr_reg;
        q_entry.data = ent_data_reg;
        q_entry.wx   = sx_reg.w;
        q_entry.wy   = sy_reg.w;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hgbs_queue.sv =====
// ----------------------------------------------------------------------------
// hgbs_queue
// Two-entry queue between the front and back sections.
// ----------------------------------------------------------------------------
`default_nettype none

module hgbs_queue
    import hgbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    output logic          full,
    input  wire logic     pop,
    output q_entry_t      head,
    output logic          empty
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

endmodule

`default_nettype wire

// ===== hw/rtl/hgbs_back.sv =====
// ----------------------------------------------------------------------------
// hgbs_back
// Grid memory, four-neighbor fetch, bilinear blend and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hgbs_back
    import hgbs_pkg::*;
#(
    parameter int GRID_MAX = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [$clog2(GRID_MAX+1)-1:0] n,
    input  wire q_entry_t                      head,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [31:0]                 altitude
);

    localparam int CAP = GRID_MAX * GRID_MAX;
    localparam int AW  = $clog2(CAP);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'h7fffffff);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

    back_state_t state_reg, state_next;

    logic signed [31:0]      mem [CAP];
    logic signed [31:0]      rd_reg;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           base_reg;
    logic signed [17:0]      wx_reg, wy_reg;
    logic signed [ACC_W-1:0] prod_reg, acc_reg;
    logic signed [MOP_W-1:0] r0_reg, r1_reg;
    logic signed [31:0]      res_reg;
    logic                    out_valid_reg;
    logic signed [31:0]      altitude_reg;

    logic                    mem_we;
    logic                    slot_free;
    logic signed [MOP_W-1:0] mop;
    logic signed [17:0]      coef;
    logic signed [ACC_W-1:0] acc_q16;
    logic signed [ACC_W-1:0] acc_sum;

    function automatic logic signed [ACC_W-1:0] trunc_q16(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] bias;
        logic signed [ACC_W-1:0] t;
        // bias negatives so the shift truncates toward zero
        bias = s[ACC_W-1] ? $signed(ACC_W'(65535)) : '0;
        t    = s + bias;
        return t >>> 16;
    endfunction

    assign slot_free = !out_valid_reg || out_ready;
    assign acc_q16   = trunc_q16(acc_reg);
    assign acc_sum   = acc_reg + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    unique case (head.kind)
                        K_WRITE: state_next = B_IDLE;
                        K_CONST: state_next = B_OUT;
                        K_READ0: state_next = B_R0;
                        K_BLEND: state_next = B_A;
                        default: state_next = B_IDLE;
                    endcase
                end
            end
            B_R0:  state_next = B_OUT;
            B_A:   state_next = B_B;
            B_B:   state_next = B_C;
            B_C:   state_next = B_D;
            B_D:   state_next = B_E;
            B_E:   state_next = B_F;
            B_F:   state_next = B_G;
            B_G:   state_next = B_H;
            B_H:   state_next = B_FIN;
            B_FIN: state_next = B_OUT;
            B_OUT:
            begin
                if (slot_free)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop     = 1'b0;
        mem_we  = 1'b0;
        rd_addr = head.addr[AW-1:0];
        mop     = MOP_W'(rd_reg);
        coef    = ONE_Q16 - wx_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                pop    = !empty;
                mem_we = !empty && (head.kind == K_WRITE);
            end
            B_A:
            begin
                rd_addr = base_reg + AW'(1);
            end
            B_B:
            begin
                rd_addr = base_reg + AW'(n);
                coef    = wx_reg;
            end
            B_C:
            begin
                rd_addr = base_reg + AW'(n) + AW'(1);
            end
            B_D:
            begin
                coef = wx_reg;
            end
            B_F:
            begin
                mop  = r0_reg;
                coef = ONE_Q16 - wy_reg;
            end
            B_G:
            begin
                mop  = r1_reg;
                coef = wy_reg;
            end
            default:
            begin
            end
        endcase
    end

    // grid memory: a write port and a registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[head.addr[AW-1:0]] <= $signed(head.data);
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ACC_W'(mop) * ACC_W'(coef);
        unique case (state_reg)
            B_IDLE:
            begin
                base_reg <= head.addr[AW-1:0];
                wx_reg   <= head.wx;
                wy_reg   <= head.wy;
                res_reg  <= '0;
            end
            B_R0:  res_reg <= rd_reg;
            B_B:   acc_reg <= prod_reg;
            B_C:   acc_reg <= acc_sum;
            B_D:
            begin
                r0_reg  <= acc_q16[MOP_W-1:0];
                acc_reg <= prod_reg;
            end
            B_E:   acc_reg <= acc_sum;
            B_F:   r1_reg  <= acc_q16[MOP_W-1:0];
            B_G:   acc_reg <= prod_reg;
            B_H:   acc_reg <= acc_sum;
            B_FIN:
            begin
                if (acc_q16 > SAT_HI)
                    res_reg <= 32'sh7fffffff;
                else if (acc_q16 < SAT_LO)
                    res_reg <= 32'sh80000000;
                else
                    res_reg <= acc_q16[31:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == B_OUT && slot_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_OUT && slot_free)
            altitude_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign altitude  = altitude_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/height_grid_bilinear_sampler.sv =====
// ----------------------------------------------------------------------------
// height_grid_bilinear_sampler
// Elevation grid store with bilinear point query and grid resampling.
// ----------------------------------------------------------------------------
// Input items (in_valid/in_ready) carry one operation: a sample write, a
// query at a normalized point, or a resample at an output column and row.
// Results leave on out_valid/out_ready as one altitude per query or resample;
// writes, unused codes and resamples with an output size of one or less give
// none. The user must write registers through cfg_we/cfg_index/cfg_data only
// while no item is in flight; the block does not enforce this. The front
// section takes one item at a time: in-range writes and trivial cases go
// straight to the push state, a query passes base and split, and a resample
// passes base, span, term, start, the serial divider (one quotient bit a
// cycle, 38 bits at GRID_MAX 256), sum and split. A two-entry queue feeds
// the back section, which reads the four neighbors from the grid memory one
// per cycle and blends them in states B_A to B_FIN before the output state
// B_OUT; a write ends in B_IDLE. Reset restores the register defaults; grid
// contents are undefined until written. When the receiver stalls, the result
// holds in the output register, the back section finishes one more item and
// then waits, and the queue and front fill up before in_ready drops for good.
// ----------------------------------------------------------------------------
`default_nettype none

module height_grid_bilinear_sampler
    import hgbs_pkg::*;
#(
    parameter int GRID_MAX = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [17:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic [15:0]        sample_index,
    input  wire logic signed [31:0] sample_value,
    input  wire logic signed [17:0] point_x,
    input  wire logic signed [17:0] point_y,
    input  wire logic [7:0]         out_col,
    input  wire logic [7:0]         out_row,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      altitude
);

    localparam int NW = $clog2(GRID_MAX + 1);

    logic [8:0] grid_size_reg;
    cfg_t       cfg_reg;
    logic [NW-1:0] n_eff;

    q_entry_t   push_entry, head;
    logic       q_push, q_full, q_pop, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg       <= '0;
            cfg_reg.rect_left   <= '0;
            cfg_reg.rect_top    <= '0;
            cfg_reg.rect_right  <= ONE_Q16;
            cfg_reg.rect_bottom <= ONE_Q16;
            cfg_reg.out_size    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_SIZE:   grid_size_reg       <= cfg_data[8:0];
                CFG_RECT_LEFT:   cfg_reg.rect_left   <= $signed(cfg_data);
                CFG_RECT_TOP:    cfg_reg.rect_top    <= $signed(cfg_data);
                CFG_RECT_RIGHT:  cfg_reg.rect_right  <= $signed(cfg_data);
                CFG_RECT_BOTTOM: cfg_reg.rect_bottom <= $signed(cfg_data);
                CFG_OUT_SIZE:    cfg_reg.out_size    <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // grid sizes above the storage fall back to the full grid
    assign n_eff = (32'(grid_size_reg) > 32'(GRID_MAX)) ? NW'(GRID_MAX) : NW'(grid_size_reg);

    hgbs_front #(.GRID_MAX(GRID_MAX)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .n            (n_eff),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .point_x      (point_x),
        .point_y      (point_y),
        .out_col      (out_col),
        .out_row      (out_row),
        .q_push       (q_push),
        .q_entry      (push_entry),
        .q_full       (q_full)
    );

    hgbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (head),
        .empty      (q_empty)
    );

    hgbs_back #(.GRID_MAX(GRID_MAX)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n_eff),
        .head      (head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .altitude  (altitude)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/hgbs_checker.sv =====
// ----------------------------------------------------------------------------
// hgbs_checker
// Port-level checks of the height grid bilinear sampler.
// ----------------------------------------------------------------------------
`default_nettype none

module hgbs_checker
    import hgbs_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic [1:0]         operation,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] altitude
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(altitude))
        else $error("result changed while stalled");

    // every query occupies the front section, so in_ready drops once it is accepted
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_QUERY |=> !in_ready)
        else $error("front took a new item right after a query");

    // an unused code is dropped and leaves the front free
    a_drop_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_UNUSED |=> in_ready)
        else $error("unused operation code stalled the front");

endmodule

bind height_grid_bilinear_sampler hgbs_checker u_hgbs_checker (.*);

`default_nettype wire

// ===== tb/height_grid_bilinear_sampler_check.sv =====
// ----------------------------------------------------------------------------
// height_grid_bilinear_sampler_check
// Watches the configuration port and both item channels of the sampler,
// keeps its own copy of the registers and the elevation grid, predicts the
// altitude of every accepted query or resample that gives one, and compares
// each result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module height_grid_bilinear_sampler_check
    import hgbs_pkg::*;
#(
    parameter int GRID_MAX = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [17:0]        cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic [15:0]        sample_index,
    input  wire logic signed [31:0] sample_value,
    input  wire logic signed [17:0] point_x,
    input  wire logic signed [17:0] point_y,
    input  wire logic [7:0]         out_col,
    input  wire logic [7:0]         out_row,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [31:0] altitude,
    output int                      fail_count,
    output int                      pending
);

    localparam longint ONE = 65536;
    localparam int     DEPTH = GRID_MAX * GRID_MAX;

    logic [31:0]        grid_copy [0:DEPTH-1];
    logic [8:0]         grid_n;
    logic [8:0]         out_m;
    logic signed [17:0] rect_l;
    logic signed [17:0] rect_t;
    logic signed [17:0] rect_r;
    logic signed [17:0] rect_b;
    logic [31:0]        altitude_q [$];
    logic [31:0]        predicted;
    logic [31:0]        oldest;

    initial begin
        for (int i = 0; i < DEPTH; i++) grid_copy[i] = '0;
    end

    function automatic longint sample_at(input longint idx);
        return longint'($signed(grid_copy[idx % DEPTH]));
    endfunction

    // cell index truncates toward zero; out-of-range cells clamp to an edge
    function automatic void split_axis(input longint pos, input longint n,
                                       output longint cpos, output longint w);
        longint i;
        i = pos / ONE;
        if (i < 0) begin
            cpos = 0;
            w    = 0;
        end else if (i >= n - 1) begin
            cpos = n - 2;
            w    = ONE;
        end else begin
            cpos = i;
            w    = pos - i * ONE;
        end
    endfunction

    function automatic logic [31:0] bilinear(input longint px, input longint py,
                                             input longint n);
        longint cx, cy, wx, wy, base, r0, r1, v;
        split_axis(px, n, cx, wx);
        split_axis(py, n, cy, wy);
        base = cx + cy * n;
        r0 = (sample_at(base) * (ONE - wx) + sample_at(base + 1) * wx) / ONE;
        r1 = (sample_at(base + n) * (ONE - wx) + sample_at(base + n + 1) * wx) / ONE;
        v  = (r0 * (ONE - wy) + r1 * wy) / ONE;
        if (v > 64'sd2147483647)  v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // returns 1 when the item gives a result
    function automatic bit predict_altitude(output logic [31:0] alt);
        longint n, m, x0, y0, dx, dy;
        n   = (grid_n > GRID_MAX) ? GRID_MAX : grid_n;
        m   = out_m;
        alt = '0;
        if (operation == OP_QUERY) begin
            if (n == 1)
                alt = grid_copy[0];
            else if (n >= 2)
                alt = bilinear(longint'(point_x) * (n - 1), longint'(point_y) * (n - 1), n);
            return 1;
        end
        if (operation == OP_RESAMPLE) begin
            if (m <= 1)
                return 0;
            if (n < 2)
                return 1;
            x0  = longint'(rect_l) * (n - 1);
            y0  = longint'(rect_t) * (n - 1);
            dx  = longint'(rect_r) * (n - 1) - x0;
            dy  = longint'(rect_b) * (n - 1) - y0;
            alt = bilinear(x0 + dx * longint'(out_col) / (m - 1),
                           y0 + dy * longint'(out_row) / (m - 1), n);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            grid_n     <= '0;
            rect_l     <= '0;
            rect_t     <= '0;
            rect_r     <= ONE_Q16;
            rect_b     <= ONE_Q16;
            out_m      <= '0;
            fail_count <= 0;
            pending    <= 0;
            altitude_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GRID_SIZE:   grid_n <= cfg_data[8:0];
                    CFG_RECT_LEFT:   rect_l <= cfg_data;
                    CFG_RECT_TOP:    rect_t <= cfg_data;
                    CFG_RECT_RIGHT:  rect_r <= cfg_data;
                    CFG_RECT_BOTTOM: rect_b <= cfg_data;
                    CFG_OUT_SIZE:    out_m  <= cfg_data[8:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                if (operation == OP_WRITE) begin
                    if (sample_index < DEPTH)
                        grid_copy[sample_index] = sample_value;
                end else if (predict_altitude(predicted)) begin
                    altitude_q.push_back(predicted);
                end
            end
            if (out_valid && out_ready) begin
                if (altitude_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 40)
                        $display("%0t altitude mismatch: expected none, actual %h",
                                 $time, altitude);
                end else begin
                    oldest = altitude_q.pop_front();
                    if (altitude !== oldest) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 40)
                            $display("%0t altitude mismatch: expected %h, actual %h",
                                     $time, oldest, altitude);
                    end
                end
            end
            pending <= altitude_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/height_grid_bilinear_sampler_test.sv =====
// ----------------------------------------------------------------------------
// height_grid_bilinear_sampler_test
// Drives writes, queries and resamples into the sampler under many register
// settings, with random gaps and output stalls; the checker beside the block
// predicts and compares every altitude.
// ----------------------------------------------------------------------------
`default_nettype none

module height_grid_bilinear_sampler_test;
    import hgbs_pkg::*;

    localparam int         LIMIT = 3000000;
    localparam int         SETTLE = 100;
    // entries loaded up front: every entry of grids up to 22 per side and the
    // first two rows of the full grid
    localparam int         PRELOAD = 512;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [17:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         operation;
    logic [15:0]        sample_index;
    logic signed [31:0] sample_value;
    logic signed [17:0] point_x;
    logic signed [17:0] point_y;
    logic [7:0]         out_col;
    logic [7:0]         out_row;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] altitude;
    int                 fail_count;
    int                 pending;

    int                 cycles = 0;
    int                 hold;
    int                 ready_gap;
    bit                 calm;
    int                 cur_n;
    int                 cur_m;

    height_grid_bilinear_sampler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .sample_index(sample_index),
        .sample_value(sample_value), .point_x(point_x), .point_y(point_y),
        .out_col(out_col), .out_row(out_row),
        .out_valid(out_valid), .out_ready(out_ready), .altitude(altitude)
    );

    height_grid_bilinear_sampler_check check (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .sample_index(sample_index),
        .sample_value(sample_value), .point_x(point_x), .point_y(point_y),
        .out_col(out_col), .out_row(out_row),
        .out_valid(out_valid), .out_ready(out_ready), .altitude(altitude),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[height_grid_bilinear_sampler] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold      <= 0;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else if (hold > 0) begin
            hold      <= hold - 1;
            out_ready <= 1'b0;
        end else begin
            ready_gap = pick_gap();
            out_ready <= (ready_gap == 0);
            hold      <= (ready_gap == 0) ? 0 : ready_gap - 1;
        end
    end

    // called at a rising edge; returns at the edge that accepted the item
    task automatic send_item(input logic [1:0] op, input logic [15:0] idx,
                             input logic [31:0] val, input logic [17:0] px,
                             input logic [17:0] py, input logic [7:0] col,
                             input logic [7:0] row);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        sample_index <= idx;
        sample_value <= val;
        point_x      <= px;
        point_y      <= py;
        out_col      <= col;
        out_row      <= row;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    // let every result out, then the block's own work on resultless items
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_registers(input int n, input logic [17:0] l, input logic [17:0] t,
                                 input logic [17:0] r, input logic [17:0] b, input int m);
        logic [17:0] vals [6];
        logic [2:0]  regs [6];
        regs = '{CFG_GRID_SIZE, CFG_RECT_LEFT, CFG_RECT_TOP,
                 CFG_RECT_RIGHT, CFG_RECT_BOTTOM, CFG_OUT_SIZE};
        vals = '{18'(n), l, t, r, b, 18'(m)};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_n = n;
        cur_m = m;
    endtask

    function automatic logic [17:0] pick_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 18'($urandom_range(0, 65536));
        if (r < 85) return 18'($urandom_range(0, 98304) - 16384);
        return 18'($urandom);
    endfunction

    // vertical position that stays on the first row of cells of the full grid
    function automatic logic [17:0] pick_low_y();
        if ($urandom_range(0, 3) != 0) return 18'($urandom_range(0, 257));
        return 18'(-$urandom_range(1, 131072));
    endfunction

    function automatic logic [17:0] pick_edge();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 18'($urandom_range(0, 81920) - 8192);
        if (r < 80) return 18'($urandom_range(0, 1) ? 131071 : -131072);
        return 18'($urandom);
    endfunction

    function automatic logic [7:0] pick_index();
        int top_i;
        top_i = (cur_m + 1 > 255) ? 255 : cur_m + 1;
        if ($urandom_range(0, 99) < 80) return 8'($urandom_range(0, top_i));
        return 8'($urandom);
    endfunction

    task automatic random_item();
        int          r;
        logic [1:0]  op;
        logic [15:0] idx;
        logic [17:0] py;
        r  = $urandom_range(0, 99);
        op = (r < 25) ? OP_WRITE : (r < 60) ? OP_QUERY : (r < 96) ? OP_RESAMPLE : OP_UNUSED;
        idx = ($urandom_range(0, 3) != 0 && cur_n > 0 && cur_n <= 256)
              ? 16'($urandom_range(0, cur_n * cur_n - 1)) : 16'($urandom);
        py = (cur_n >= 256) ? pick_low_y() : pick_point();
        send_item(op, idx, $urandom, pick_point(), py, pick_index(), pick_index());
    endtask

    task automatic random_phase();
        int          r, n, m;
        logic [17:0] e;
        r = $urandom_range(0, 99);
        n = (r < 60) ? $urandom_range(2, 8) : (r < 70) ? $urandom_range(0, 1) :
            (r < 80) ? 256 : (r < 88) ? $urandom_range(257, 511) : $urandom_range(9, 22);
        r = $urandom_range(0, 99);
        m = (r < 60) ? $urandom_range(2, 12) : (r < 70) ? $urandom_range(0, 1) :
            (r < 85) ? 256 : $urandom_range(13, 511);
        if (n >= 256) begin
            // flat rectangle on the first row of cells
            e = pick_low_y();
            set_registers(n, pick_edge(), e, pick_edge(), e, m);
        end else if ($urandom_range(0, 4) == 0)
            set_registers(n, 18'd0, 18'd0, 18'd65536, 18'd65536, m);
        else
            set_registers(n, pick_edge(), pick_edge(), pick_edge(), pick_edge(), m);
        calm = ($urandom_range(0, 3) == 0);
        repeat (150) random_item();
        drain();
    endtask

    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        operation    = OP_WRITE;
        sample_index = '0;
        sample_value = '0;
        point_x      = '0;
        point_y      = '0;
        out_col      = '0;
        out_row      = '0;
        calm         = 1'b0;
        cur_n        = 0;
        cur_m        = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty grid: no result depends on the grid memory yet
        set_registers(0, 18'd0, 18'd0, 18'd65536, 18'd65536, 4);
        send_item(OP_QUERY, 16'd0, 32'd0, 18'd0, 18'd0, 8'd0, 8'd0);
        send_item(OP_RESAMPLE, 16'd0, 32'd0, 18'd0, 18'd0, 8'd1, 8'd1);
        send_item(OP_UNUSED, 16'hffff, 32'hffffffff, 18'h3ffff, 18'h3ffff, 8'hff, 8'hff);
        drain();

        // load every entry that a later read can touch
        calm = 1'b1;
        for (int i = 0; i < PRELOAD; i++)
            send_item(OP_WRITE, 16'(i), $urandom, 18'd0, 18'd0, 8'd0, 8'd0);
        calm = 1'b0;
        drain();

        // single sample; resample with a one-point output gives nothing
        set_registers(1, 18'd0, 18'd0, 18'd65536, 18'd65536, 1);
        send_item(OP_WRITE, 16'd0, 32'h7fffffff, 18'd0, 18'd0, 8'd0, 8'd0);
        send_item(OP_QUERY, 16'd0, 32'd0, 18'd12345, 18'd54321, 8'd0, 8'd0);
        send_item(OP_RESAMPLE, 16'd0, 32'd0, 18'd0, 18'd0, 8'd0, 8'd0);
        drain();

        // 2x2 grid at the value extremes, negative weights, clamped cells
        set_registers(2, -18'sd131072, -18'sd131072, 18'sd131071, 18'sd131071, 2);
        send_item(OP_WRITE, 16'd0, 32'h80000000, 18'd0, 18'd0, 8'd0, 8'd0);
        send_item(OP_WRITE, 16'd1, 32'h7fffffff, 18'd0, 18'd0, 8'd0, 8'd0);
        send_item(OP_WRITE, 16'd2, 32'h7fffffff, 18'd0, 18'd0, 8'd0, 8'd0);
        send_item(OP_WRITE, 16'd3, 32'h80000000, 18'd0, 18'd0, 8'd0, 8'd0);
        send_item(OP_QUERY, 16'd0, 32'd0, 18'd0, 18'd0, 8'd0, 8'd0);
        send_item(OP_QUERY, 16'd0, 32'd0, 18'd65536, 18'd65536, 8'd0, 8'd0);
        send_item(OP_QUERY, 16'd0, 32'd0, -18'sd1, -18'sd30000, 8'd0, 8'd0);
        send_item(OP_QUERY, 16'd0, 32'd0, 18'sd131071, -18'sd131072, 8'd0, 8'd0);
        send_item(OP_QUERY, 16'd0, 32'd0, 18'd32768, 18'd32768, 8'd0, 8'd0);
        send_item(OP_RESAMPLE, 16'd0, 32'd0, 18'd0, 18'd0, 8'd0, 8'd0);
        send_item(OP_RESAMPLE, 16'd0, 32'd0, 18'd0, 18'd0, 8'd1, 8'd1);
        send_item(OP_RESAMPLE, 16'd0, 32'd0, 18'd0, 18'd0, 8'd255, 8'd255);
        drain();

        // oversized grid and output registers
        set_registers(511, 18'sd131071, -18'sd131072, -18'sd131072, 18'sd131071, 511);
        send_item(OP_WRITE, 16'hffff, 32'h7fffffff, 18'd0, 18'd0, 8'd0, 8'd0);
        send_item(OP_QUERY, 16'd0, 32'd0, 18'd65535, 18'd1, 8'd0, 8'd0);
        send_item(OP_RESAMPLE, 16'd0, 32'd0, 18'd0, 18'd0, 8'd255, 8'd0);
        drain();

        repeat (10) random_phase();

        if (fail_count == 0)
            $display("[height_grid_bilinear_sampler] OK");
        else
            $display("[height_grid_bilinear_sampler] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
